// ----- sv/iircf_pkg.sv -----
// ============================================================================
// iircf_pkg - shared types, constants and helpers for the IIR compensator
// Widths, register map and fixed-point conversions used by every module.
// ============================================================================
package iircf_pkg;

    // feedforward taps in use (1..3); feedback uses one fewer
    localparam int FILTER_TAPS    = 3;
    localparam int COEF_FRAC_BITS = 14;

    localparam int NUM_REGS   = 5;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int ACC_W      = 48;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int FF_W       = PROD_W + $clog2(FILTER_TAPS);
    localparam int FULL_FB_W  = ACC_W + COEF_W;
    localparam int FB_W       = FULL_FB_W - COEF_FRAC_BITS;
    localparam int WIDE_W     = (FB_W > ACC_W) ? FB_W : ACC_W;
    localparam int SUM_W      = WIDE_W + 2;
    localparam int INT_W      = ACC_W - COEF_FRAC_BITS;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = $clog2(4 * NUM_REGS);
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    // register map, word index
    localparam logic [REG_IDX_W-1:0] REG_B0 = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_B1 = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_B2 = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_A1 = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_A2 = REG_IDX_W'(4);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [FB_W-1:0]     fb_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef coef_t [NUM_REGS-1:0]       coef_bank_t;

    localparam coef_t COEF_B0_RESET = 18'sd16384;

    localparam acc_t    ACC_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
    localparam acc_t    ACC_MIN    = {1'b1, {(ACC_W-1){1'b0}}};
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // clamp the wide accumulator sum to ACC_W bits
    function automatic acc_t sat_acc(input sum_t v);
        acc_t r;
        if (v[SUM_W-1:ACC_W-1] == {(SUM_W-ACC_W+1){v[ACC_W-1]}}) begin
            r = v[ACC_W-1:0];
        end else if (v[SUM_W-1]) begin
            r = ACC_MIN;
        end else begin
            r = ACC_MAX;
        end
        return r;
    endfunction

    // drop fraction toward zero, then clamp to a 16-bit sample
    function automatic sample_t acc_to_sample(input acc_t a);
        logic signed [INT_W-1:0] q;
        logic                    frac_nz;
        sample_t                 r;
        q       = a[ACC_W-1:COEF_FRAC_BITS];
        frac_nz = |a[COEF_FRAC_BITS-1:0];
        if (a[ACC_W-1] && frac_nz) begin
            q = q + {{(INT_W-1){1'b0}}, 1'b1};
        end
        if (q[INT_W-1:SAMPLE_W-1] == {(INT_W-SAMPLE_W+1){q[SAMPLE_W-1]}}) begin
            r = q[SAMPLE_W-1:0];
        end else if (q[INT_W-1]) begin
            r = SAMPLE_MIN;
        end else begin
            r = SAMPLE_MAX;
        end
        return r;
    endfunction

endpackage

// ----- sv/iircf_tap_cell.sv -----
// ============================================================================
// iircf_tap_cell - feedforward tap cell
// Holds one input history sample and registers its weighted product.
// ============================================================================
module iircf_tap_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  iircf_pkg::sample_t sample_in,
    input  iircf_pkg::coef_t   coef,
    output iircf_pkg::sample_t sample_out,
    output iircf_pkg::prod_t   prod_out
);
    import iircf_pkg::*;

    sample_t sample_reg, sample_next;
    prod_t   prod_reg, prod_next;

    always_comb begin
        sample_next = sample_reg;
        prod_next   = prod_reg;
        if (advance) begin
            sample_next = sample_in;
            prod_next   = PROD_W'(sample_in) * PROD_W'(coef);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else begin
            sample_reg <= sample_next;
        end
        prod_reg <= prod_next;
    end

    assign sample_out = sample_reg;
    assign prod_out   = prod_reg;

endmodule

// ----- sv/iircf_fb_cell.sv -----
// ============================================================================
// iircf_fb_cell - feedback tap cell
// Holds one output history value and its scaled feedback term.
// ============================================================================
module iircf_fb_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  iircf_pkg::acc_t  y_in,
    input  iircf_pkg::coef_t coef,
    output iircf_pkg::acc_t  y_out,
    output iircf_pkg::fb_t   fb_out
);
    import iircf_pkg::*;

    acc_t                        y_reg, y_next;
    fb_t                         fb_reg, fb_next;
    logic signed [FULL_FB_W-1:0] full_prod;

    // term tracks the held value, so a coefficient write shows up next cycle
    always_comb begin
        y_next    = advance ? y_in : y_reg;
        full_prod = FULL_FB_W'(y_next) * FULL_FB_W'(coef);
        fb_next   = full_prod[FULL_FB_W-1:COEF_FRAC_BITS];   // floor shift
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_reg  <= '0;
            fb_reg <= '0;
        end else begin
            y_reg  <= y_next;
            fb_reg <= fb_next;
        end
    end

    assign y_out  = y_reg;
    assign fb_out = fb_reg;

endmodule

// ----- sv/iircf_apb_regs.sv -----
// ============================================================================
// iircf_apb_regs - coefficient register bank
// APB write/read of the five Q4.14 coefficients.
// ============================================================================
module iircf_apb_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [iircf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [iircf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [iircf_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    output iircf_pkg::coef_bank_t            coefs
);
    import iircf_pkg::*;

    coef_bank_t             coefs_reg, coefs_next;
    logic [REG_IDX_W-1:0]   idx;
    logic                   idx_ok;
    logic                   wr_en;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign idx_ok = (idx <= REG_A2);
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        coefs_next = coefs_reg;
        if (wr_en && idx_ok) begin
            coefs_next[idx] = pwdata[COEF_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // b0 sits in the lowest slot and resets to 1.0, the rest to zero
            coefs_reg <= {{((NUM_REGS-1)*COEF_W){1'b0}}, COEF_B0_RESET};
        end else begin
            coefs_reg <= coefs_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (idx_ok) begin
            prdata[COEF_W-1:0] = coefs_reg[idx];
        end
    end

    assign pready = 1'b1;
    assign coefs  = coefs_reg;

endmodule

// ----- sv/iir_compensator_filter.sv -----
// ============================================================================
// iir_compensator_filter - second-order direct-form-I compensator
// y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2, Q4.14 coefficients, 48-bit
// saturating output history, 16-bit saturated integer output.
// ============================================================================
//
//  channel   ports                          word / use
//  -------   -----------------------------  ----------------------------------
//  input     s_valid s_ready s_sample_in    one signed 16-bit error sample
//  output    m_valid m_ready m_sample_out   one signed 16-bit filter output
//  config    psel penable pwrite paddr ...  coef b0,b1,b2,a1,a2 at 0x0..0x10
//
//  One word in and one word out per cycle sustained while m_ready is high.
//  Stage 3 sets m_valid. The rate is set by the feedback loop: output
//  history cell 1's 48x18 multiply plus the accumulate and clamp, one pass
//  per word. Reset (aresetn low, synchronous) clears both histories and
//  loads b0 = 1.0, others 0. With m_ready low the output word holds and the
//  two inner stages keep filling, so up to three words sit in the block.
//
// Pipeline:
//   stage 1  tap cells shift the input history and register b_k * x[n-k]
//   stage 2  feedforward sum of the tap products
//   stage 3  accumulate minus feedback terms, clamp to 48 bits, shift the
//            output history cells, register the 16-bit output word
//
module iir_compensator_filter (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  iircf_pkg::sample_t               s_sample_in,
    // output channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output iircf_pkg::sample_t               m_sample_out,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [iircf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [iircf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [iircf_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import iircf_pkg::*;

    coef_bank_t coefs;

    // pipeline control
    logic    v1_reg, v1_next;
    logic    v2_reg, v2_next;
    logic    m_valid_reg, m_valid_next;
    logic    adv1, adv2, adv3;

    // datapath
    sample_t           tap_sample [FILTER_TAPS+1];
    prod_t             tap_prod   [FILTER_TAPS];
    logic signed [FF_W-1:0] ff_sum, ff_term;
    logic signed [FF_W-1:0] ff_reg, ff_next;
    acc_t              fb_y   [FILTER_TAPS];
    fb_t               fb_val [FILTER_TAPS];
    sum_t              acc_sum, acc_term;
    acc_t              acc_new;
    sample_t           m_sample_out_reg, m_sample_out_next;

    iircf_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coefs   (coefs)
    );

    // ---- handshake: each stage moves when the one after it has room ----
    assign adv3    = v2_reg && (!m_valid_reg || m_ready);
    assign adv2    = v1_reg && (!v2_reg || adv3);
    assign s_ready = !v1_reg || adv2;
    assign adv1    = s_valid && s_ready;

    always_comb begin
        v1_next      = adv1 ? 1'b1 : (adv2 ? 1'b0 : v1_reg);
        v2_next      = adv2 ? 1'b1 : (adv3 ? 1'b0 : v2_reg);
        m_valid_next = adv3 ? 1'b1 : ((m_valid_reg && m_ready) ? 1'b0 : m_valid_reg);
    end

    // ---- stage 1: input history row, one tap cell per feedforward tap ----
    assign tap_sample[0] = s_sample_in;

    for (genvar k = 0; k < FILTER_TAPS; k++) begin : g_tap
        iircf_tap_cell u_tap (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .advance    (adv1),
            .sample_in  (tap_sample[k]),
            .coef       (coefs[REG_B0 + REG_IDX_W'(k)]),
            .sample_out (tap_sample[k+1]),
            .prod_out   (tap_prod[k])
        );
    end

    // ---- stage 2: feedforward sum ----
    always_comb begin
        ff_sum  = '0;
        ff_term = '0;
        for (int k = 0; k < FILTER_TAPS; k++) begin
            ff_term = FF_W'(tap_prod[k]);
            ff_sum  = ff_sum + ff_term;
        end
        ff_next = adv2 ? ff_sum : ff_reg;
    end

    // ---- stage 3: output history row; cell j holds y[n-j] and a_j*y[n-j] ----
    assign fb_y[0]   = acc_new;
    assign fb_val[0] = '0;

    for (genvar j = 1; j < FILTER_TAPS; j++) begin : g_fb
        iircf_fb_cell u_fb (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (adv3),
            .y_in    (fb_y[j-1]),
            .coef    (coefs[REG_A1 + REG_IDX_W'(j-1)]),
            .y_out   (fb_y[j]),
            .fb_out  (fb_val[j])
        );
    end

    always_comb begin
        acc_sum  = SUM_W'(ff_reg);
        acc_term = '0;
        for (int j = 0; j < FILTER_TAPS; j++) begin
            acc_term = SUM_W'(fb_val[j]);
            acc_sum  = acc_sum - acc_term;
        end
        acc_new           = sat_acc(acc_sum);
        m_sample_out_next = adv3 ? acc_to_sample(fb_y[0]) : m_sample_out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            m_valid_reg <= m_valid_next;
        end
        ff_reg           <= ff_next;
        m_sample_out_reg <= m_sample_out_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;

    // ---- checks ----
    a_out_from_stage2: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(v2_reg))
        else $error("output word appeared without a stage 2 word");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!v1_reg && !v2_reg) |-> s_ready)
        else $error("input not ready with empty pipeline");

    a_history_holds_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !adv3)
        else $error("output history advanced while output stalled");

    a_pos_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv3 && acc_new == ACC_MAX) |=> (m_sample_out_reg == SAMPLE_MAX))
        else $error("clamped accumulator did not give full-scale output");

    a_neg_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv3 && acc_new == ACC_MIN) |=> (m_sample_out_reg == SAMPLE_MIN))
        else $error("clamped accumulator did not give negative full scale");

endmodule
